[hw/rtl/kcsg_pkg.sv]
// kcsg_pkg: widths, fixed-point constants and shared types of the koch curve
// segment generator. No dependencies; every other file imports it.

package kcsg_pkg;

   localparam int COORD_W     = 24;               // coordinate width, 8 fraction bits
   localparam int DIFF_W      = COORD_W + 1;      // exact difference of two coordinates
   localparam int COEF_W      = 17;               // signed q0.16 coefficient
   localparam int PROD_W      = DIFF_W + COEF_W;  // exact product
   localparam int RND_SHIFT   = 16;
   localparam int COS_SHIFT   = 15;               // cos(120) is -1/2, a shift
   localparam int STACK_DEPTH = 10;
   localparam int STACK_AW    = 4;
   localparam int LVL_W       = 2;

   localparam logic signed [COEF_W-1:0] K_THIRD      = 17'sd21845;
   localparam logic signed [COEF_W-1:0] K_TWO_THIRDS = 17'sd43691;
   localparam logic signed [COEF_W-1:0] K_SIN120     = 17'sd56756;
   localparam logic signed [COEF_W-1:0] K_NSIN120    = -17'sd56756;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      point_type         pt;
      logic [LVL_W-1:0]  lvl;
   } entry_type;

   // one job for the shared multiply-round unit: base + round((diff*coef + offs) / 2^16)
   typedef struct packed {
      logic signed [DIFF_W-1:0]  diff;
      logic signed [COEF_W-1:0]  coef;
      logic signed [PROD_W-1:0]  offs;
      logic signed [COORD_W-1:0] base;
   } mul_op_type;

endpackage

[hw/rtl/kcsg_ifs.sv]
// kcsg_ifs: valid/ready channel interfaces of the koch curve segment generator
// (request, response, csr write). Depends on kcsg_pkg.

interface kcsg_req_if import kcsg_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [COORD_W-1:0] point_a_x;
   logic signed [COORD_W-1:0] point_a_y;
   logic signed [COORD_W-1:0] point_b_x;
   logic signed [COORD_W-1:0] point_b_y;

   modport source (output valid, action, point_a_x, point_a_y, point_b_x, point_b_y,
                   input ready);
   modport sink   (input valid, action, point_a_x, point_a_y, point_b_x, point_b_y,
                   output ready);
endinterface

interface kcsg_rsp_if import kcsg_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] seg_x0;
   logic signed [COORD_W-1:0] seg_y0;
   logic signed [COORD_W-1:0] seg_x1;
   logic signed [COORD_W-1:0] seg_y1;
   logic                      last_segment;

   modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, last_segment,
                   input ready);
   modport sink   (input valid, seg_x0, seg_y0, seg_x1, seg_y1, last_segment,
                   output ready);
endinterface

interface kcsg_csr_if import kcsg_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LVL_W-1:0] subdivision_depth;

   modport source (output valid, subdivision_depth, input ready);
   modport sink   (input valid, subdivision_depth, output ready);
endinterface

[hw/rtl/kcsg_mul_unit.sv]
// kcsg_mul_unit: shared multiply, add and round unit; the job is registered, then added and rounded.
// Depends on kcsg_pkg.

module kcsg_mul_unit import kcsg_pkg::*; (
   input  logic                      clock,
   input  mul_op_type                op,
   output logic signed [COORD_W-1:0] result
);

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  offs_ff;
   logic signed [COORD_W-1:0] base_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W:0]    sum;

   assign prod_in = PROD_W'($signed(op.diff) * $signed(op.coef));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      offs_ff <= op.offs;
      base_ff <= op.base;
   end

   // add a half and floor, then wrap into the coordinate width
   assign sum    = {prod_ff[PROD_W-1], prod_ff} + {offs_ff[PROD_W-1], offs_ff}
                   + (PROD_W+1)'(1 << (RND_SHIFT - 1));
   assign result = base_ff + sum[RND_SHIFT+COORD_W-1:RND_SHIFT];

endmodule

[hw/rtl/koch_curve_segment_generator.sv]
// koch_curve_segment_generator: top level, sequencer, pending stack and output register.
// Depends on kcsg_pkg, kcsg_ifs and kcsg_mul_unit.
//
// usage
//  req_bus takes one word: action 0 draws a koch line from point a to point b,
//  action 1 draws a snowflake with center a and first corner b (depth capped at 2).
//  rsp_bus returns the segments in drawing order, last_segment marks the final one.
//  csr_bus writes subdivision_depth (0..3); write it only while the block is idle.
//  req_bus.ready is high only while idle; one request is worked at a time.
//  each subdivision is one stack pop, six multiply-round jobs on the single shared
//  multiplier and four stack pushes. each segment is popped and emitted in the same step.
//  a snowflake first rotates the corners on the shared multiplier and adds one
//  side-setup step per side.
//  the response side is a single output register; while the receiver stalls, the
//  sequencer holds at the next segment and resumes when the register is taken.
//  synchronous reset returns the sequencer to idle, empties the stack, drops
//  rsp valid and sets subdivision_depth to 0. no clearing pass is needed.

module koch_curve_segment_generator import kcsg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   kcsg_req_if.sink     req_bus,
   kcsg_rsp_if.source   rsp_bus,
   kcsg_csr_if.sink     csr_bus
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CORN = 3'd1;
   localparam logic [2:0] S_SIDE = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_CALC = 3'd4;
   localparam logic [2:0] S_PUSH = 3'd5;

   localparam logic [2:0] OP_CORN_LAST = 3'd3;
   localparam logic [2:0] OP_CALC_LAST = 3'd5;
   localparam logic [2:0] OP_PUSH_LAST = 3'd3;
   localparam logic [1:0] SIDE_LAST    = 2'd2;
   localparam logic [LVL_W-1:0] FLAKE_MAX_LVL = 2'd2;

   logic [2:0]            state_ff, state_in;
   logic [STACK_AW-1:0]   sp_ff, sp_in;
   logic [2:0]            op_ff, op_in;
   logic                  phase_ff, phase_in;
   logic [1:0]            side_ff, side_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]      depth_ff;

   logic                  flake_ff;
   logic [LVL_W-1:0]      fdepth_ff;
   logic [LVL_W-1:0]      lvl_ff;
   point_type             cur_ff, end_ff, one_ff, two_ff, top_ff;
   point_type             ctr_ff, c1_ff, c2_ff, c3_ff;
   entry_type             stack_ff [STACK_DEPTH];

   point_type             rsp_p0_ff, rsp_p1_ff;
   logic                  rsp_last_ff;

   logic                  req_fire;
   logic                  out_free;
   logic [STACK_AW-1:0]   sp_dec;
   entry_type             pop_entry;
   logic                  emit;
   logic                  emit_last;
   logic                  side_done;
   point_type             side_start, side_end;
   logic [LVL_W-1:0]      req_depth;

   logic                  st_we;
   logic [STACK_AW-1:0]   st_wa;
   entry_type             st_wd;

   mul_op_type            mop;
   logic signed [COORD_W-1:0] mul_result;

   logic                  is_rot, is_y;
   point_type             rp, rc, lp, lq;
   logic signed [COEF_W-1:0]  lk;
   logic signed [DIFF_W-1:0]  dx, dy, dl;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign sp_dec        = sp_ff - STACK_AW'(1);
   assign pop_entry     = stack_ff[sp_dec];
   assign emit          = (state_ff == S_POP) && (pop_entry.lvl == '0) && out_free;
   assign side_done     = (sp_dec == '0);
   assign emit_last     = side_done && (!flake_ff || side_ff == SIDE_LAST);
   assign req_depth     = (req_bus.action && depth_ff > FLAKE_MAX_LVL) ? FLAKE_MAX_LVL
                                                                    : depth_ff;

   // snowflake sides run c1->c3, c3->c2, c2->c1
   always_comb begin
      case (side_ff)
         2'd0: begin
            side_start = c1_ff;
            side_end   = c3_ff;
         end
         2'd1: begin
            side_start = c3_ff;
            side_end   = c2_ff;
         end
         default: begin
            side_start = c2_ff;
            side_end   = c1_ff;
         end
      endcase
   end

   // job decode for the shared unit
   always_comb begin
      is_y = op_ff[0];
      lp   = cur_ff;
      lq   = end_ff;
      lk   = op_ff[1] ? K_TWO_THIRDS : K_THIRD;
      if (state_ff == S_CORN) begin
         is_rot = 1'b1;
         rp     = op_ff[1] ? c2_ff : c1_ff;
         rc     = ctr_ff;
      end else begin
         is_rot = op_ff[2];
         rp     = end_ff;
         rc     = two_ff;
      end
      dx = {rp.x[COORD_W-1], rp.x} - {rc.x[COORD_W-1], rc.x};
      dy = {rp.y[COORD_W-1], rp.y} - {rc.y[COORD_W-1], rc.y};
      dl = is_y ? ({lq.y[COORD_W-1], lq.y} - {lp.y[COORD_W-1], lp.y})
                : ({lq.x[COORD_W-1], lq.x} - {lp.x[COORD_W-1], lp.x});
      if (is_rot) begin
         // x' = cx + rnd(-dx/2 * 2^16 - dy*sin), y' = cy + rnd(dx*sin - dy/2 * 2^16)
         mop.diff = is_y ? dx : dy;
         mop.coef = is_y ? K_SIN120 : K_NSIN120;
         mop.offs = is_y ? -{{(PROD_W-DIFF_W-COS_SHIFT){dy[DIFF_W-1]}}, dy, COS_SHIFT'(0)}
                         : -{{(PROD_W-DIFF_W-COS_SHIFT){dx[DIFF_W-1]}}, dx, COS_SHIFT'(0)};
         mop.base = is_y ? rc.y : rc.x;
      end else begin
         mop.diff = dl;
         mop.coef = lk;
         mop.offs = '0;
         mop.base = is_y ? lp.y : lp.x;
      end
   end

   kcsg_mul_unit u_mul (
      .clock  (clock),
      .op     (mop),
      .result (mul_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      st_we        = 1'b0;
      st_wa        = sp_ff;
      st_wd.pt     = end_ff;
      st_wd.lvl    = lvl_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = '0;
               phase_in = 1'b0;
               side_in  = '0;
               if (req_bus.action) begin
                  state_in = S_CORN;
               end else begin
                  st_we     = 1'b1;
                  st_wa     = '0;
                  st_wd.pt  = '{x: req_bus.point_b_x, y: req_bus.point_b_y};
                  st_wd.lvl = req_depth;
                  sp_in     = STACK_AW'(1);
                  state_in  = S_POP;
               end
            end
         end
         S_CORN, S_CALC: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               op_in = op_ff + 3'd1;
               if (state_ff == S_CORN && op_ff == OP_CORN_LAST) begin
                  state_in = S_SIDE;
               end else if (state_ff == S_CALC && op_ff == OP_CALC_LAST) begin
                  op_in    = '0;
                  state_in = S_PUSH;
               end
            end
         end
         S_SIDE: begin
            st_we     = 1'b1;
            st_wa     = '0;
            st_wd.pt  = side_end;
            st_wd.lvl = fdepth_ff;
            sp_in     = STACK_AW'(1);
            state_in  = S_POP;
         end
         S_POP: begin
            if (pop_entry.lvl != '0) begin
               sp_in    = sp_dec;
               op_in    = '0;
               phase_in = 1'b0;
               state_in = S_CALC;
            end else if (emit) begin
               sp_in = sp_dec;
               if (side_done) begin
                  if (emit_last) begin
                     state_in = S_IDLE;
                  end else begin
                     side_in  = side_ff + 2'd1;
                     state_in = S_SIDE;
                  end
               end
            end
         end
         S_PUSH: begin
            // push order end, two-thirds point, peak, one-third point
            st_we = 1'b1;
            case (op_ff[1:0])
               2'd0:    st_wd.pt = end_ff;
               2'd1:    st_wd.pt = two_ff;
               2'd2:    st_wd.pt = top_ff;
               default: st_wd.pt = one_ff;
            endcase
            sp_in = sp_ff + STACK_AW'(1);
            op_in = op_ff + 3'd1;
            if (op_ff == OP_PUSH_LAST) begin
               state_in = S_POP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         op_ff        <= '0;
         phase_ff     <= 1'b0;
         side_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            depth_ff <= csr_bus.subdivision_depth;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_ff[st_wa] <= st_wd;
      end
   end

   // working points
   always_ff @(posedge clock) begin
      if (req_fire) begin
         flake_ff  <= req_bus.action;
         fdepth_ff <= req_depth;
         ctr_ff    <= '{x: req_bus.point_a_x, y: req_bus.point_a_y};
         c1_ff     <= '{x: req_bus.point_b_x, y: req_bus.point_b_y};
         cur_ff    <= '{x: req_bus.point_a_x, y: req_bus.point_a_y};
      end
      if (state_ff == S_SIDE) begin
         cur_ff <= side_start;
      end
      if (state_ff == S_POP && pop_entry.lvl != '0) begin
         end_ff <= pop_entry.pt;
         lvl_ff <= pop_entry.lvl - LVL_W'(1);
      end
      if (emit) begin
         cur_ff      <= pop_entry.pt;
         rsp_p0_ff   <= cur_ff;
         rsp_p1_ff   <= pop_entry.pt;
         rsp_last_ff <= emit_last;
      end
      if (state_ff == S_CORN && phase_ff) begin
         case (op_ff[1:0])
            2'd0:    c2_ff.x <= mul_result;
            2'd1:    c2_ff.y <= mul_result;
            2'd2:    c3_ff.x <= mul_result;
            default: c3_ff.y <= mul_result;
         endcase
      end
      if (state_ff == S_CALC && phase_ff) begin
         case (op_ff)
            3'd0:    one_ff.x <= mul_result;
            3'd1:    one_ff.y <= mul_result;
            3'd2:    two_ff.x <= mul_result;
            3'd3:    two_ff.y <= mul_result;
            3'd4:    top_ff.x <= mul_result;
            default: top_ff.y <= mul_result;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.seg_x0       = rsp_p0_ff.x;
   assign rsp_bus.seg_y0       = rsp_p0_ff.y;
   assign rsp_bus.seg_x1       = rsp_p1_ff.x;
   assign rsp_bus.seg_y1       = rsp_p1_ff.y;
   assign rsp_bus.last_segment = rsp_last_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= STACK_AW'(STACK_DEPTH))
      else $error("pending stack overflow");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (sp_ff == '0))
      else $error("idle with pending entries");

   a_emit_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_POP))
      else $error("segment produced outside the pop step");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> (state_ff == S_IDLE))
      else $error("last segment did not end the request");

   a_calc_op_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> (op_ff <= OP_CALC_LAST))
      else $error("job index out of range");

endmodule

[verif/koch_curve_segment_generator_tb.sv]
// koch_curve_segment_generator_tb: self-checking bench for the koch curve segment generator.
// Drives line and snowflake words at all subdivision depths and checks every segment.
// Depends on kcsg_pkg, kcsg_ifs and the koch_curve_segment_generator rtl.

module koch_curve_segment_generator_tb;
   import kcsg_pkg::*;

   localparam logic ACT_LINE  = 1'b0;
   localparam logic ACT_FLAKE = 1'b1;

   localparam longint THIRD_Q16      = 21845;
   localparam longint TWO_THIRDS_Q16 = 43691;
   localparam longint COS120_Q16     = -32768;
   localparam longint SIN120_Q16     = 56756;
   localparam int     STACK_SLOTS    = 10;
   localparam int     MAX_SEGS       = 64;
   localparam int     FLAKE_DEPTH_CAP = 2;
   localparam int     LONG_HOLD_CYCLES = 400;

   localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-(2 ** (COORD_W - 1)));
   localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'((2 ** (COORD_W - 1)) - 1);

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
   } koch_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic                      last;
   } segment_type;

   typedef struct packed {
      longint x;
      longint y;
   } xy_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock;
   logic reset;

   kcsg_req_if req_bus ();
   kcsg_rsp_if rsp_bus ();
   kcsg_csr_if csr_bus ();

   koch_curve_segment_generator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   koch_req_type pending_reqs[$];
   segment_type  expected_segs[$];
   segment_type  item_segs[$];

   int depth_setting = 0;
   int issued_total = 0;
   int accepted_total = 0;
   int error_count = 0;
   int lines_sent = 0;
   int flakes_sent = 0;
   int segs_checked = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int mode_left = 0;
   int burst_left = 0;
   int gap_left = 0;
   logic [7:0] rx_tick = '0;
   rx_mode_type rx_mode = RX_ALWAYS;
   koch_req_type next_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("koch_curve_segment_generator_tb: FAIL");
      $finish;
   end

   // ---------------- prediction ----------------

   function automatic longint wrap_coord(longint v);
      logic signed [COORD_W-1:0] t;
      t = v[COORD_W-1:0];
      return longint'(t);
   endfunction

   // add one half, then floor
   function automatic longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic xy_type lerp_pt(xy_type p, xy_type q, longint c);
      xy_type r;
      r.x = wrap_coord(p.x + round_q16((q.x - p.x) * c));
      r.y = wrap_coord(p.y + round_q16((q.y - p.y) * c));
      return r;
   endfunction

   function automatic xy_type turn_120(xy_type p, xy_type c);
      longint dx;
      longint dy;
      xy_type r;
      dx = p.x - c.x;
      dy = p.y - c.y;
      r.x = wrap_coord(c.x + round_q16(dx * COS120_Q16 - dy * SIN120_Q16));
      r.y = wrap_coord(c.y + round_q16(dx * SIN120_Q16 + dy * COS120_Q16));
      return r;
   endfunction

   // depth-first subdivision of one side, segments appended to item_segs
   task automatic trace_koch_side(input xy_type p, input xy_type q, input int level);
      xy_type stk_pt[STACK_SLOTS];
      int  stk_lvl[STACK_SLOTS];
      xy_type kids[4];
      xy_type cur;
      xy_type e;
      xy_type two;
      int  sp;
      int  lv;
      segment_type seg;
      cur = p;
      stk_pt[0] = q;
      stk_lvl[0] = level;
      sp = 1;
      while (sp > 0 && item_segs.size() < MAX_SEGS) begin
         sp--;
         e = stk_pt[sp];
         lv = stk_lvl[sp];
         if (lv == 0) begin
            seg.x0 = cur.x[COORD_W-1:0];
            seg.y0 = cur.y[COORD_W-1:0];
            seg.x1 = e.x[COORD_W-1:0];
            seg.y1 = e.y[COORD_W-1:0];
            seg.last = 1'b0;
            item_segs.push_back(seg);
            cur = e;
         end else begin
            two = lerp_pt(cur, e, TWO_THIRDS_Q16);
            kids[0] = e;
            kids[1] = two;
            kids[2] = turn_120(e, two);
            kids[3] = lerp_pt(cur, e, THIRD_Q16);
            for (int k = 0; k < 4; k++) begin
               if (sp < STACK_SLOTS) begin
                  stk_pt[sp] = kids[k];
                  stk_lvl[sp] = lv - 1;
                  sp++;
               end
            end
         end
      end
   endtask

   task automatic predict_koch_segments(input koch_req_type r);
      xy_type a;
      xy_type b;
      xy_type c1;
      xy_type c2;
      int depth;
      segment_type seg;
      a.x = longint'(r.ax);
      a.y = longint'(r.ay);
      b.x = longint'(r.bx);
      b.y = longint'(r.by);
      depth = depth_setting;
      item_segs.delete();
      if (r.action == ACT_LINE) begin
         trace_koch_side(a, b, depth);
      end else begin
         if (depth > FLAKE_DEPTH_CAP) depth = FLAKE_DEPTH_CAP;
         c1 = turn_120(b, a);
         c2 = turn_120(c1, a);
         trace_koch_side(b, c2, depth);
         trace_koch_side(c2, c1, depth);
         trace_koch_side(c1, b, depth);
      end
      seg = item_segs.pop_back();
      seg.last = 1'b1;
      item_segs.push_back(seg);
      foreach (item_segs[i]) expected_segs.push_back(item_segs[i]);
   endtask

   // ---------------- driver and monitors ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_bus.valid <= 1'b0;
         end else begin
            next_req = pending_reqs.pop_front();
            req_bus.action    <= next_req.action;
            req_bus.point_a_x <= next_req.ax;
            req_bus.point_a_y <= next_req.ay;
            req_bus.point_b_x <= next_req.bx;
            req_bus.point_b_y <= next_req.by;
            req_bus.valid     <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
      end
   end

   always @(posedge clock) begin
      koch_req_type got_req;
      if (!reset && req_bus.valid && req_bus.ready) begin
         got_req.action = req_bus.action;
         got_req.ax = req_bus.point_a_x;
         got_req.ay = req_bus.point_a_y;
         got_req.bx = req_bus.point_b_x;
         got_req.by = req_bus.point_b_y;
         predict_koch_segments(got_req);
         if (got_req.action == ACT_FLAKE) flakes_sent++;
         else lines_sent++;
         accepted_total++;
      end
   end

   always @(posedge clock) begin
      rx_tick <= rx_tick + 8'd1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
               RX_ALWAYS:   rsp_bus.ready <= 1'b1;
               RX_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_bus.ready <= (rx_tick[2:0] != 3'd5) && !rx_tick[4];
            endcase
         end
      end
   end

   task automatic check_field(input string name, input logic signed [COORD_W-1:0] want,
                              input logic signed [COORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_segs.size() == 0) begin
            $error("segment word with nothing expected: (%0d,%0d)->(%0d,%0d)",
                   rsp_bus.seg_x0, rsp_bus.seg_y0, rsp_bus.seg_x1, rsp_bus.seg_y1);
            error_count++;
         end else begin
            want = expected_segs.pop_front();
            check_field("seg_x0", want.x0, rsp_bus.seg_x0);
            check_field("seg_y0", want.y0, rsp_bus.seg_y0);
            check_field("seg_x1", want.x1, rsp_bus.seg_x1);
            check_field("seg_y1", want.y1, rsp_bus.seg_y1);
            check_field("last_segment", COORD_W'(want.last), COORD_W'(rsp_bus.last_segment));
            segs_checked++;
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic logic signed [COORD_W-1:0] rand_span(int bits);
      logic [31:0] r;
      longint v;
      r = $urandom;
      if (bits >= COORD_W - 1) return r[COORD_W-1:0];
      v = longint'(r % (32'd1 << (bits + 1))) - (longint'(1) << bits);
      return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] edge_coord();
      case ($urandom_range(0, 4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return rand_span(COORD_W - 1);
      endcase
   endfunction

   function automatic koch_req_type random_koch_req();
      koch_req_type r;
      int style;
      r.action = ($urandom_range(0, 1) == 1) ? ACT_FLAKE : ACT_LINE;
      style = $urandom_range(0, 9);
      if (style <= 1) begin
         r.ax = rand_span(COORD_W - 1);
         r.ay = rand_span(COORD_W - 1);
         r.bx = rand_span(COORD_W - 1);
         r.by = rand_span(COORD_W - 1);
      end else if (style <= 6) begin
         // plausible drawing: nearby points inside the plane
         r.ax = rand_span(18);
         r.ay = rand_span(18);
         r.bx = r.ax + rand_span(14);
         r.by = r.ay + rand_span(14);
      end else if (style == 7) begin
         r.ax = rand_span(6);
         r.ay = rand_span(6);
         r.bx = rand_span(6);
         r.by = rand_span(6);
      end else if (style == 8) begin
         r.ax = edge_coord();
         r.ay = edge_coord();
         r.bx = edge_coord();
         r.by = edge_coord();
      end else begin
         r.ax = rand_span(20);
         r.ay = rand_span(20);
         r.bx = r.ax;
         r.by = r.ay;
      end
      return r;
   endfunction

   task automatic queue_req(input logic act, input logic signed [COORD_W-1:0] ax,
                            input logic signed [COORD_W-1:0] ay,
                            input logic signed [COORD_W-1:0] bx,
                            input logic signed [COORD_W-1:0] by);
      koch_req_type r;
      r.action = act;
      r.ax = ax;
      r.ay = ay;
      r.bx = bx;
      r.by = by;
      pending_reqs.push_back(r);
      issued_total++;
   endtask

   task automatic wait_all_segments();
      while (accepted_total != issued_total || expected_segs.size() != 0) @(posedge clock);
   endtask

   task automatic write_depth(input logic [LVL_W-1:0] value);
      @(posedge clock);
      csr_bus.subdivision_depth <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      depth_setting = value;
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int phase_depth[8];
      int phase_items[8];
      koch_req_type r;
      phase_depth = '{1, 0, 3, 2, 1, 0, 2, 3};
      phase_items = '{45, 40, 20, 35, 40, 35, 30, 15};

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_LINE;
      req_bus.point_a_x = '0;
      req_bus.point_a_y = '0;
      req_bus.point_b_x = '0;
      req_bus.point_b_y = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.subdivision_depth = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // depth 0 straight out of reset
      queue_req(ACT_LINE, '0, '0, 24'sh000300, '0);
      queue_req(ACT_LINE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      queue_req(ACT_LINE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      queue_req(ACT_LINE, 24'sd1234, -24'sd77, 24'sd1234, -24'sd77);
      queue_req(ACT_FLAKE, '0, '0, 24'sh001000, '0);
      queue_req(ACT_FLAKE, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      wait_all_segments();

      // deepest setting; the flake gets capped, extremes wrap
      write_depth(2'd3);
      queue_req(ACT_LINE, '0, '0, 24'sh009000, '0);
      queue_req(ACT_LINE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      queue_req(ACT_LINE, -24'sd1, -24'sd1, 24'sd1, 24'sd1);
      queue_req(ACT_FLAKE, '0, '0, '0, 24'sh002000);
      queue_req(ACT_FLAKE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      wait_all_segments();

      write_depth(2'd1);
      queue_req(ACT_LINE, -24'sh000100, 24'sh000080, 24'sh000700, -24'sh000300);
      queue_req(ACT_FLAKE, 24'sd5, -24'sd5, 24'sd5, -24'sd5);
      queue_req(ACT_LINE, COORD_MAX, '0, COORD_MIN, '0);
      wait_all_segments();

      write_depth(2'd2);
      queue_req(ACT_LINE, '0, COORD_MIN, '0, COORD_MAX);
      queue_req(ACT_FLAKE, 24'sh123456, -24'sh054321, 24'sh1234f0, -24'sh050000);
      queue_req(ACT_LINE, 24'sd1, '0, '0, 24'sd1);
      queue_req(ACT_FLAKE, -24'sd3, 24'sd7, 24'sd2, -24'sd2);
      wait_all_segments();

      for (int ph = 0; ph < 8; ph++) begin
         write_depth(phase_depth[ph][LVL_W-1:0]);
         // long output stall while the sender keeps offering
         if (ph == 1) hold_requests++;
         for (int i = 0; i < phase_items[ph]; i++) begin
            if (ph == 3 && i == phase_items[ph] / 2) wait_all_segments();
            r = random_koch_req();
            queue_req(r.action, r.ax, r.ay, r.bx, r.by);
         end
         wait_all_segments();
      end

      repeat (100) @(posedge clock);
      if (expected_segs.size() != 0) begin
         $error("%0d expected segments never arrived", expected_segs.size());
         error_count++;
      end
      $display("run covered %0d lines and %0d snowflakes at depths 0 to 3, %0d segments checked",
               lines_sent, flakes_sent, segs_checked);
      $display("including coordinate extremes, a long output stall and a full drain mid-phase");
      if (error_count == 0) begin
         $display("koch_curve_segment_generator_tb: PASS");
      end else begin
         $display("koch_curve_segment_generator_tb: FAIL");
      end
      $finish;
   end

endmodule
